FILE: rtl/drive_run_state_sequencer_unit_assert.svh
// assertion macros shared by the sequencer checker
// needs nothing but a clock and an active-high reset in the using scope
`ifndef DRIVE_RUN_STATE_SEQUENCER_UNIT_ASSERT_SVH
`define DRIVE_RUN_STATE_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DRSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drss: same-cycle check failed");

// next-cycle implication, disabled in reset
`define DRSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drss: next-cycle check failed");

`endif

FILE: rtl/drss_pkg.sv
// types and constants of the drive run-state sequencer
// no dependencies
package drss_pkg;

  localparam int CmdW   = 2;
  localparam int RefW   = 32;
  localparam int FaultW = 48;
  localparam int MonW   = 7;
  localparam int ReqW   = 2;
  localparam int BrakeW = 4;
  localparam int ModeW  = 4;
  localparam int TolW   = 16;
  localparam int AddrW  = 4;
  localparam int DataW  = 64;

  localparam logic [CmdW-1:0] CMD_RUN  = 2'd1;
  localparam logic [CmdW-1:0] CMD_HALT = 2'd2;

  localparam logic [BrakeW-1:0] BRAKE_RELEASED = 4'd3;
  localparam logic [TolW-1:0]   TOL_RESET      = 16'd66;

  // register index is paddr bit 3 (8-byte spacing)
  localparam logic REG_FAULT_MASK = 1'b0;
  localparam logic REG_SETTLE_TOL = 1'b1;

  // monitor flag bit positions
  localparam int MON_INIT_CAL  = 0;
  localparam int MON_DRIVE_CAL = 1;
  localparam int MON_PWM_ON    = 2;
  localparam int MON_BRAKE_CTL = 3;
  localparam int MON_ACCEL     = 4;
  localparam int MON_DECEL     = 5;
  localparam int MON_FAULT_RST = 6;

  // operator request bit positions
  localparam int REQ_CAL  = 0;
  localparam int REQ_TUNE = 1;

  typedef enum logic [ModeW-1:0] {
    MODE_POWER_ON  = 4'd0,
    MODE_INIT_CAL  = 4'd1,
    MODE_DRIVE_CAL = 4'd2,
    MODE_STOP      = 4'd3,
    MODE_READY     = 4'd4,
    MODE_BRAKING   = 4'd5,
    MODE_ACCEL     = 4'd6,
    MODE_DECEL     = 4'd7,
    MODE_RUNNING   = 4'd8,
    MODE_TUNING    = 4'd9,
    MODE_FAULT     = 4'd10
  } mode_t;

  typedef struct packed {
    logic [FaultW-1:0] fault_ignore_mask;
    logic [TolW-1:0]   settle_tolerance;
  } drss_cfg_t;

  typedef struct packed {
    mode_t               mode;
    logic                run_flag;
    logic [RefW-1:0]     captured_reference;
  } drss_state_t;

  typedef struct packed {
    logic [CmdW-1:0]        command;
    logic signed [RefW-1:0] target_reference;
    logic signed [RefW-1:0] ramped_reference;
    logic [FaultW-1:0]      fault_bits;
    logic [MonW-1:0]        monitor_flags;
    logic [ReqW-1:0]        operator_requests;
    logic [BrakeW-1:0]      brake_step;
    logic                   tuning_done;
  } drss_item_t;

endpackage

FILE: rtl/drss_if.sv
// valid/ready channel interfaces for sequencer input beats and result beats
// depends on drss_pkg
interface drss_item_if import drss_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CmdW-1:0]        command;
  logic signed [RefW-1:0] target_reference;
  logic signed [RefW-1:0] ramped_reference;
  logic [FaultW-1:0]      fault_bits;
  logic [MonW-1:0]        monitor_flags;
  logic [ReqW-1:0]        operator_requests;
  logic [BrakeW-1:0]      brake_step;
  logic                   tuning_done;

  modport source (
    output valid, command, target_reference, ramped_reference, fault_bits,
           monitor_flags, operator_requests, brake_step, tuning_done,
    input  ready
  );
  modport sink (
    input  valid, command, target_reference, ramped_reference, fault_bits,
           monitor_flags, operator_requests, brake_step, tuning_done,
    output ready
  );
endinterface

interface drss_result_if import drss_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ModeW-1:0]       drive_state;
  logic                   run_status;
  logic                   tuning_restart;
  logic signed [RefW-1:0] held_reference;

  modport source (
    output valid, drive_state, run_status, tuning_restart, held_reference,
    input  ready
  );
  modport sink (
    input  valid, drive_state, run_status, tuning_restart, held_reference,
    output ready
  );
endinterface

FILE: rtl/drive_run_state_sequencer_unit.sv
// an accepted input beat is registered in the input stage, then its result in the result stage
// throughput: one beat per cycle while the result channel is not stalled, set by the combinational mode step logic
// reset (rst, synchronous): mode power on, run flag 0, held reference 0,
// fault mask 0, settle tolerance 66; both channel stages empty
module drive_run_state_sequencer_unit import drss_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  drss_item_if.sink        item,
  drss_result_if.source    result
);

  // configuration registers
  drss_cfg_t cfg;

  // input stage: one registered beat waiting for the step logic
  logic       s1_valid;
  drss_item_t s1_item;

  // sequencer state and its next value from the step logic
  drss_state_t state;
  drss_state_t state_next;
  logic        restart_next;

  // result stage
  logic        res_valid;
  mode_t       res_mode;
  logic        res_run;
  logic        res_restart;
  logic [RefW-1:0] res_held;

  logic out_free;
  logic step_fire;

  drss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  drss_step u_step (
    .cur     (state),
    .item    (s1_item),
    .cfg     (cfg),
    .nxt     (state_next),
    .restart (restart_next)
  );

  // result register is free when empty or being drained this cycle
  assign out_free   = !res_valid || result.ready;
  // the staged beat steps the machine when the result slot can take it
  assign step_fire  = s1_valid && out_free;
  // input stage refills whenever it is empty or moving on
  assign item.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_item.command           <= item.command;
      s1_item.target_reference  <= item.target_reference;
      s1_item.ramped_reference  <= item.ramped_reference;
      s1_item.fault_bits        <= item.fault_bits;
      s1_item.monitor_flags     <= item.monitor_flags;
      s1_item.operator_requests <= item.operator_requests;
      s1_item.brake_step        <= item.brake_step;
      s1_item.tuning_done       <= item.tuning_done;
    end
  end

  // machine state only moves when a beat is stepped
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode               <= MODE_POWER_ON;
      state.run_flag           <= 1'b0;
      state.captured_reference <= '0;
    end else if (step_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
  end

  // result payload carries the state after the step
  always_ff @(posedge clk) begin
    if (step_fire) begin
      res_mode    <= state_next.mode;
      res_run     <= state_next.run_flag;
      res_restart <= restart_next;
      res_held    <= state_next.captured_reference;
    end
  end

  assign result.valid          = res_valid;
  assign result.drive_state    = ModeW'(res_mode);
  assign result.run_status     = res_run;
  assign result.tuning_restart = res_restart;
  assign result.held_reference = res_held;

endmodule

FILE: rtl/drss_cfg.sv
// apb register bank: fault ignore mask and settle tolerance
// depends on drss_pkg
module drss_cfg import drss_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output drss_cfg_t        cfg
);

  logic wr;
  logic sel;

  assign pready = 1'b1;
  assign sel    = paddr[3];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fault_ignore_mask <= '0;
      cfg.settle_tolerance  <= TOL_RESET;
    end else if (wr) begin
      if (sel == REG_FAULT_MASK) begin
        cfg.fault_ignore_mask <= pwdata[FaultW-1:0];
      end else begin
        cfg.settle_tolerance <= pwdata[TolW-1:0];
      end
    end
  end

  always_comb begin
    if (sel == REG_SETTLE_TOL) begin
      prdata = {{(DataW-TolW){1'b0}}, cfg.settle_tolerance};
    end else begin
      prdata = {{(DataW-FaultW){1'b0}}, cfg.fault_ignore_mask};
    end
  end

endmodule

FILE: rtl/drss_step.sv
// next-state logic of the drive mode machine for one tick
// depends on drss_pkg
module drss_step import drss_pkg::*; (
  input  drss_state_t cur,
  input  drss_item_t  item,
  input  drss_cfg_t   cfg,
  output drss_state_t nxt,
  output logic        restart
);

  logic                   fault;
  mode_t                  mode;
  logic signed [RefW:0]   diff;
  logic signed [RefW:0]   tol;
  logic                   near;
  logic                   same;
  logic                   tgt_zero;
  logic                   is_run;
  logic                   is_stop;

  assign fault    = |(item.fault_bits & ~cfg.fault_ignore_mask);
  assign mode     = fault ? MODE_FAULT : cur.mode;
  assign diff     = {item.target_reference[RefW-1], item.target_reference}
                  - {item.ramped_reference[RefW-1], item.ramped_reference};
  assign tol      = $signed({{(RefW+1-TolW){1'b0}}, cfg.settle_tolerance});
  assign near     = (diff <= tol) && (diff >= -tol);
  assign same     = item.target_reference == item.ramped_reference;
  assign tgt_zero = item.target_reference == '0;
  assign is_run   = item.command == CMD_RUN;
  assign is_stop  = item.command == CMD_HALT;

  always_comb begin
    nxt      = cur;
    nxt.mode = mode;
    restart  = 1'b0;
    case (mode)
      MODE_POWER_ON: begin
        nxt.mode     = MODE_INIT_CAL;
        nxt.run_flag = 1'b0;
      end
      MODE_INIT_CAL: begin
        if (item.monitor_flags[MON_INIT_CAL]) nxt.mode = MODE_STOP;
      end
      MODE_DRIVE_CAL: begin
        if (!item.operator_requests[REQ_CAL] && item.monitor_flags[MON_DRIVE_CAL]) begin
          nxt.mode = MODE_STOP;
        end
      end
      MODE_STOP: begin
        if (is_run && !tgt_zero) begin
          if (item.monitor_flags[MON_PWM_ON]) begin
            nxt.mode = item.monitor_flags[MON_BRAKE_CTL] ? MODE_BRAKING : MODE_ACCEL;
          end
          nxt.run_flag = 1'b1;
        end else if (is_stop && !item.monitor_flags[MON_PWM_ON]) begin
          nxt.mode     = MODE_READY;
          nxt.run_flag = 1'b0;
        end
      end
      MODE_READY: begin
        if (is_run) begin
          nxt.mode     = MODE_STOP;
          nxt.run_flag = 1'b1;
        end else if (item.operator_requests[REQ_CAL]) begin
          nxt.mode     = MODE_DRIVE_CAL;
          nxt.run_flag = 1'b1;
        end else if (item.operator_requests[REQ_TUNE]) begin
          nxt.mode     = MODE_TUNING;
          nxt.run_flag = 1'b1;
          restart      = 1'b1;
        end
      end
      MODE_BRAKING: begin
        if (is_run && item.brake_step >= BRAKE_RELEASED) begin
          nxt.mode = MODE_ACCEL;
        end else if (is_stop) begin
          nxt.mode               = MODE_DECEL;
          nxt.captured_reference = item.ramped_reference;
        end
      end
      MODE_ACCEL: begin
        if (!item.monitor_flags[MON_ACCEL]) begin
          if (near) nxt.mode = MODE_RUNNING;
          else if (item.monitor_flags[MON_DECEL]) nxt.mode = MODE_DECEL;
        end
      end
      MODE_DECEL: begin
        if (same) begin
          if (tgt_zero) nxt.mode = MODE_STOP;
          else if (is_run) nxt.mode = MODE_RUNNING;
        end else if (item.monitor_flags[MON_ACCEL]) begin
          nxt.mode = MODE_ACCEL;
        end
      end
      MODE_RUNNING: begin
        if (same && tgt_zero) nxt.mode = MODE_STOP;
        else if (item.monitor_flags[MON_ACCEL]) nxt.mode = MODE_ACCEL;
        else if (item.monitor_flags[MON_DECEL]) nxt.mode = MODE_DECEL;
      end
      MODE_TUNING: begin
        if (!item.operator_requests[REQ_TUNE] && item.tuning_done) nxt.mode = MODE_STOP;
      end
      MODE_FAULT: begin
        nxt.run_flag = 1'b0;
        if (item.monitor_flags[MON_FAULT_RST]) nxt.mode = MODE_STOP;
      end
      default: begin
        nxt.mode = mode;
      end
    endcase
  end

endmodule

FILE: rtl/drss_checker.sv
// port-level checks on the sequencer result channel, bound to the top level
// depends on drss_pkg and drive_run_state_sequencer_unit_assert.svh
`include "drive_run_state_sequencer_unit_assert.svh"

module drss_checker import drss_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   valid,
  input logic                   ready,
  input logic [ModeW-1:0]       drive_state,
  input logic                   run_status,
  input logic                   tuning_restart,
  input logic signed [RefW-1:0] held_reference
);

  logic stalled;
  logic idle_mode;

  assign stalled   = valid && !ready;
  // modes that are only reached with the run flag clear
  assign idle_mode = drive_state == ModeW'(MODE_READY)
                  || drive_state == ModeW'(MODE_INIT_CAL)
                  || drive_state == ModeW'(MODE_FAULT);

  `DRSS_ASSERT_NEXT(a_result_holds, clk, rst, stalled,
    valid && $stable(drive_state) && $stable(run_status) && $stable(held_reference))
  `DRSS_ASSERT_NOW(a_restart_in_tuning, clk, rst, valid && tuning_restart,
    drive_state == ModeW'(MODE_TUNING) && run_status)
  `DRSS_ASSERT_NOW(a_idle_not_running, clk, rst, valid && idle_mode, !run_status)
  `DRSS_ASSERT_NEXT(a_held_only_in_decel, clk, rst,
    valid && ready && drive_state != ModeW'(MODE_DECEL),
    !valid || drive_state == ModeW'(MODE_DECEL) || held_reference == $past(held_reference))

endmodule

bind drive_run_state_sequencer_unit drss_checker u_drss_checker (
  .clk            (clk),
  .rst            (rst),
  .valid          (result.valid),
  .ready          (result.ready),
  .drive_state    (result.drive_state),
  .run_status     (result.run_status),
  .tuning_restart (result.tuning_restart),
  .held_reference (result.held_reference)
);
